FILE: rtl/point_set_min_sq_distance_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point set minimum distance block
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_SET_MIN_SQ_DISTANCE_DEFINES_SVH
`define POINT_SET_MIN_SQ_DISTANCE_DEFINES_SVH

// Same-cycle implication
`define PSMSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PSMSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/psmsd_pkg.sv
// ----------------------------------------------------------------------------
// psmsd_pkg
// Types, sizes and codes shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package psmsd_pkg;

    // Store and point geometry
    localparam int MAX_POINTS = 64;
    localparam int MAX_DIM    = 8;
    localparam int COORD_BITS = 16;

    // Fixed field widths of the stream items
    localparam int DIM_W         = 4;
    localparam int COORD_FIELD_W = 16;
    localparam int CEIL_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 7;
    localparam int CFG_DATA_W    = 32;

    localparam int IN_BITS   = DIM_W + MAX_DIM * COORD_FIELD_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + 2 * CEIL_W + COUNT_FIELD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Derived storage and arithmetic widths
    localparam int ADDR_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int ROW_W    = MAX_DIM * COORD_BITS;
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int PAIRS    = (MAX_DIM + 1) / 2;
    localparam int LANE_PAD = 2 * PAIRS;
    localparam int PAIR_W   = SQ_W + 1;
    localparam int SUM_W    = SQ_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);
    localparam int CMP_W    = (SUM_W > CEIL_W) ? SUM_W : CEIL_W;
    localparam int PIPE_DEPTH = 5;

    // Reset values of the configuration and running minimum
    localparam logic [DIM_W-1:0]  DIM_RESET     = DIM_W'(2);
    localparam logic [CEIL_W-1:0] CEILING_RESET = CEIL_W'(10000);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_DIMENSION = 1'b0,
        CFG_CEILING   = 1'b1
    } cfg_index_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        RES_ADDED     = 2'd0,
        RES_DUPLICATE = 2'd1,
        RES_DIM_ERR   = 2'd2,
        RES_FULL      = 2'd3
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming point, restart the scan
        logic issue;   // read the next stored point into the pipeline
        logic commit;  // decide, update state and load the output register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic dim_match;  // captured point has the configured dimension
        logic scan_done;  // every stored point has been issued
        logic pipe_busy;  // distance pipeline still holds work
        logic out_free;   // output register can take a new result
    } dp_status_t;

endpackage

FILE: rtl/point_set_min_sq_distance.sv
// ----------------------------------------------------------------------------
// point_set_min_sq_distance
// Nearest neighbor scan over a growing point set with a running minimum of
// the squared distances between inserted points.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point per request: claimed dimension and eight
//   coordinates. m_axis returns one result per request: status, nearest
//   squared distance, running minimum and stored point count.
//   The cfg port writes the dimension (index 0) and the distance ceiling
//   (index 1); write it only while no request is in flight.
// Timing:
//   A request with a matching dimension feeds one stored point per cycle
//   from a single store read port into a five-stage distance pipeline. The
//   result is registered once the pipeline has drained, straight after the
//   scan with an empty store, and without a scan on a dimension mismatch.
//   One request is in work at a time; the next is accepted once the
//   controller has returned to idle after the result is registered.
// Reset and stall:
//   Reset empties the store, sets dimension 2 and ceiling 10000 and the
//   running minimum to 10000. A stalled receiver holds the result in the
//   output register; a finished request then waits before committing.
// ----------------------------------------------------------------------------
module point_set_min_sq_distance (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [psmsd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // point_dim[3:0], coord_0[19:4], coord_1[35:20], ... coord_7[131:116], zero pad
    input  logic [psmsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status[1:0], nearest_sq_distance[33:2], set_min_sq_distance[65:34],
    // point_count[72:66], zero pad
    output logic [psmsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import psmsd_pkg::*;

    ctl_cmd_t                               cmd;
    dp_status_t                             status;
    logic [MAX_DIM-1:0][COORD_FIELD_W-1:0]  coords;
    logic [STATUS_W-1:0]                    out_status;
    logic [CEIL_W-1:0]                      out_nearest;
    logic [CEIL_W-1:0]                      out_set_min;
    logic [CNT_W-1:0]                       out_count;

    // Unpack the request coordinates
    always_comb
    begin
        for (int k = 0; k < MAX_DIM; k++)
        begin
            coords[k] = s_axis_tdata[DIM_W + k*COORD_FIELD_W +: COORD_FIELD_W];
        end
    end

    psmsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psmsd_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_dim   (s_axis_tdata[DIM_W-1:0]),
        .coords      (coords),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (out_status),
        .out_nearest (out_nearest),
        .out_set_min (out_set_min),
        .out_count   (out_count)
    );

    // Pack the result
    assign m_axis_tdata = OUT_DATA_W'({COUNT_FIELD_W'(out_count), out_set_min,
                                       out_nearest, out_status});

endmodule

FILE: rtl/psmsd_ctrl.sv
// ----------------------------------------------------------------------------
// psmsd_ctrl
// Sequencer: accepts a request, steps the scan over stored points (skipped on
// a dimension mismatch), waits for the distance pipeline to drain and commits the result.
// ----------------------------------------------------------------------------
`include "point_set_min_sq_distance_defines.svh"

module psmsd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  psmsd_pkg::dp_status_t status,
    output psmsd_pkg::ctl_cmd_t   cmd
);
    import psmsd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (!status.dim_match)
                begin
                    state_next = ST_DECIDE;
                end
                else if (status.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PSMSD_ASSERT_IMP(a_commit_drained, cmd.commit, !status.pipe_busy, "commit with busy pipeline")
    `PSMSD_ASSERT_NXT(a_load_leaves_idle, cmd.load, state_reg != ST_IDLE, "idle after request")

endmodule

FILE: rtl/psmsd_dpath.sv
// ----------------------------------------------------------------------------
// psmsd_dpath
// Point store, squared distance pipeline, running minimum, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
`include "point_set_min_sq_distance_defines.svh"

module psmsd_dpath (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     cfg_we,
    input  logic                                                     cfg_index,
    input  logic [psmsd_pkg::CFG_DATA_W-1:0]                         cfg_data,
    input  logic [psmsd_pkg::DIM_W-1:0]                              point_dim,
    input  logic [psmsd_pkg::MAX_DIM-1:0][psmsd_pkg::COORD_FIELD_W-1:0] coords,
    input  psmsd_pkg::ctl_cmd_t                                      cmd,
    output psmsd_pkg::dp_status_t                                    status,
    output logic                                                     out_valid,
    input  logic                                                     out_ready,
    output logic [psmsd_pkg::STATUS_W-1:0]                           out_status,
    output logic [psmsd_pkg::CEIL_W-1:0]                             out_nearest,
    output logic [psmsd_pkg::CEIL_W-1:0]                             out_set_min,
    output logic [psmsd_pkg::CNT_W-1:0]                              out_count
);
    import psmsd_pkg::*;

    // Configuration
    logic [DIM_W-1:0]  dimension_reg;
    logic [CEIL_W-1:0] ceiling_reg;

    // Request and scan state
    logic [COORD_BITS-1:0] point_reg [MAX_DIM];
    logic                  dim_match_reg;
    logic [CNT_W-1:0]      scan_cnt_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CEIL_W-1:0]     running_min_reg;
    logic [CEIL_W-1:0]     best_reg;
    logic                  dup_reg;

    // Point store
    logic [ROW_W-1:0] mem [MAX_POINTS];
    logic [ROW_W-1:0] wr_row;

    // Distance pipeline
    logic [PIPE_DEPTH-1:0] pipe_v_reg;
    logic [ROW_W-1:0]      rd_data_reg;
    logic [COORD_BITS-1:0] abs_reg  [LANE_PAD];
    logic [COORD_BITS-1:0] abs_next [LANE_PAD];
    logic [SQ_W-1:0]       sq_reg   [LANE_PAD];
    logic [PAIR_W-1:0]     pair_reg [PAIRS];
    logic [SUM_W-1:0]      total_reg;
    logic [SUM_W-1:0]      total_next;

    // Output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [CEIL_W-1:0]     out_nearest_reg;
    logic [CEIL_W-1:0]     out_set_min_reg;
    logic [CNT_W-1:0]      out_count_reg;

    result_t           res_code;
    logic              is_full;
    logic              lower_min;
    logic [CEIL_W-1:0] set_min_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIM_RESET;
            ceiling_reg   <= CEILING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DIMENSION: dimension_reg <= cfg_data[DIM_W-1:0];
                CFG_CEILING:   ceiling_reg   <= cfg_data[CEIL_W-1:0];
                default:       dimension_reg <= dimension_reg;
            endcase
        end
    end

    // Capture the request point, keeping the low COORD_BITS of each field
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < MAX_DIM; k++)
            begin
                point_reg[k] <= coords[k][COORD_BITS-1:0];
            end
            dim_match_reg <= (point_dim == dimension_reg);
        end
    end

    // Pack the captured point as a store row
    always_comb
    begin
        for (int k = 0; k < MAX_DIM; k++)
        begin
            wr_row[k*COORD_BITS +: COORD_BITS] = point_reg[k];
        end
    end

    // Store write on insert, registered read while scanning
    always_ff @(posedge clk)
    begin
        if (cmd.commit && res_code == RES_ADDED)
        begin
            mem[count_reg[ADDR_W-1:0]] <= wr_row;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[scan_cnt_reg[ADDR_W-1:0]];
        end
    end

    // Absolute coordinate differences, unused lanes forced to zero
    always_comb
    begin
        logic signed [COORD_BITS:0] diff;
        logic [COORD_BITS-1:0]      stored;
        for (int k = 0; k < LANE_PAD; k++)
        begin
            abs_next[k] = '0;
        end
        for (int k = 0; k < MAX_DIM; k++)
        begin
            stored = rd_data_reg[k*COORD_BITS +: COORD_BITS];
            diff   = $signed({stored[COORD_BITS-1], stored})
                   - $signed({point_reg[k][COORD_BITS-1], point_reg[k]});
            if (DIM_W'(k) < dimension_reg)
            begin
                abs_next[k] = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
            end
        end
    end

    // Final sum of the pair sums
    always_comb
    begin
        total_next = '0;
        for (int p = 0; p < PAIRS; p++)
        begin
            total_next = total_next + SUM_W'(pair_reg[p]);
        end
    end

    // Pipeline stages: difference, square, pair sum, total
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LANE_PAD; k++)
        begin
            abs_reg[k] <= abs_next[k];
            sq_reg[k]  <= SQ_W'(abs_reg[k]) * SQ_W'(abs_reg[k]);
        end
        for (int p = 0; p < PAIRS; p++)
        begin
            pair_reg[p] <= PAIR_W'(sq_reg[2*p]) + PAIR_W'(sq_reg[2*p+1]);
        end
        total_reg <= total_next;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_v_reg <= '0;
        end
        else
        begin
            pipe_v_reg <= {pipe_v_reg[PIPE_DEPTH-2:0], cmd.issue};
        end
    end

    // Scan counter, nearest distance and duplicate flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            dup_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            scan_cnt_reg <= '0;
            dup_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (pipe_v_reg[PIPE_DEPTH-1] && total_reg == '0)
            begin
                dup_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            best_reg <= ceiling_reg;
        end
        else if (pipe_v_reg[PIPE_DEPTH-1] && CMP_W'(total_reg) < CMP_W'(best_reg))
        begin
            best_reg <= total_reg[CEIL_W-1:0];
        end
    end

    // Outcome of the request
    assign is_full = (count_reg == CNT_W'(MAX_POINTS));

    always_comb
    begin
        priority if (!dim_match_reg)
        begin
            res_code = RES_DIM_ERR;
        end
        else if (dup_reg)
        begin
            res_code = RES_DUPLICATE;
        end
        else if (is_full)
        begin
            res_code = RES_FULL;
        end
        else
        begin
            res_code = RES_ADDED;
        end
    end

    assign lower_min    = (res_code == RES_ADDED) && (count_reg != '0)
                        && (best_reg < running_min_reg);
    assign set_min_next = lower_min ? best_reg : running_min_reg;

    // Count and running minimum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            running_min_reg <= CEILING_RESET;
        end
        else if (cmd.commit)
        begin
            if (res_code == RES_ADDED)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            running_min_reg <= set_min_next;
        end
    end

    // Output register: load on commit, hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg  <= res_code;
            out_nearest_reg <= (res_code == RES_ADDED) ? best_reg : '0;
            out_set_min_reg <= set_min_next;
            out_count_reg   <= (res_code == RES_ADDED) ? count_reg + CNT_W'(1) : count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_nearest = out_nearest_reg;
    assign out_set_min = out_set_min_reg;
    assign out_count   = out_count_reg;

    // Status to the controller
    always_comb
    begin
        status.dim_match = dim_match_reg;
        status.scan_done = (scan_cnt_reg == count_reg);
        status.pipe_busy = |pipe_v_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    `PSMSD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_POINTS), "count beyond store")
    `PSMSD_ASSERT_IMP(a_issue_in_range, cmd.issue, scan_cnt_reg < count_reg, "scan past count")
    `PSMSD_ASSERT_NXT(a_min_falls, 1'b1, running_min_reg <= $past(running_min_reg), "min rose")

endmodule
